[rtl/block_cache_lru_directory_unit_assert.svh]
// Assertion macros shared by the directory RTL.
// Each macro expands to one labelled concurrent assertion, sampled on the rising edge
// of clk and switched off while rst is high.
`ifndef BLOCK_CACHE_LRU_DIRECTORY_UNIT_ASSERT_SVH
`define BLOCK_CACHE_LRU_DIRECTORY_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCLRU_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bclru: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BCLRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bclru: assertion failed");

`endif

[rtl/bclru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block cache directory package
// Field widths, operation and status codes, entry layout and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bclru_pkg;

   localparam int DEFAULT_ENTRIES = 32;

   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int DEVICE_W = 8;
   localparam int BLOCK_W  = 32;
   localparam int ENTRY_W  = 5;
   localparam int COUNT_W  = 8;
   localparam int STAMP_W  = 64;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_GET     = 2'd0,
      OP_RELEASE = 2'd1,
      OP_PIN     = 2'd2,
      OP_BAD     = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_FREE = 2'd1,
      STATUS_FAULT   = 2'd2
   } status_type;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [DEVICE_W-1:0] device;
      logic [BLOCK_W-1:0]  block_number;
      logic [ENTRY_W-1:0]  entry_index;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                hit;
      logic                needs_fill;
      logic [ENTRY_W-1:0]  entry_out;
      logic [COUNT_W-1:0]  count_out;
   } rsp_payload_type;

   // One directory entry as held in the RAM.
   typedef struct packed {
      logic                present;
      logic                data_valid;
      logic [COUNT_W-1:0]  count;
      logic [STAMP_W-1:0]  stamp;
      logic [DEVICE_W-1:0] device;
      logic [BLOCK_W-1:0]  block;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_READ,
      ST_COMMIT,
      ST_REJECT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic scan_start;
      logic scan_step;
      logic target_read;
      logic commit;
      logic reject;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   index_ok;
      logic   scan_last;
      logic   found;
      logic   slot_free;
   } dp_status_type;

endpackage

[rtl/bclru_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready stream channel
// A transaction moves on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface bclru_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/bclru_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bclru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/bclru_ctrl.sv]
`timescale 1ns / 1ps
`include "block_cache_lru_directory_unit_assert.svh"
// ----------------------------------------------------------------------------
// Block cache directory controller
// Sequences each transaction: dispatch, directory scan for a get, then
// target read and commit, or reject, into the response register.
// ----------------------------------------------------------------------------
module bclru_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bclru_pkg::dp_status_type sts,
   output bclru_pkg::ctrl_cmd_type  cmd
);
   import bclru_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority if (sts.op == OP_GET) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else if (sts.op == OP_BAD || !sts.index_ok) begin
               state_in = ST_REJECT;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         // last entry read is evaluated here
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (sts.found) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_REJECT;
            end
         end
         ST_READ: begin
            cmd.target_read = 1'b1;
            state_in        = ST_COMMIT;
         end
         // hold until the response register has room
         ST_COMMIT: begin
            if (sts.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_REJECT: begin
            if (sts.slot_free) begin
               cmd.reject = 1'b1;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

   `BCLRU_ASSERT_NEXT(a_accept_dispatch, clock, reset, cmd.accept, state_ff == ST_DISPATCH)
   `BCLRU_ASSERT_NEXT(a_scan_drain, clock, reset, cmd.scan_step && sts.scan_last, state_ff == ST_DRAIN)
   `BCLRU_ASSERT_NEXT(a_load_idle, clock, reset, cmd.commit || cmd.reject, req_ready)
endmodule

[rtl/bclru_datapath.sv]
`timescale 1ns / 1ps
`include "block_cache_lru_directory_unit_assert.svh"
// ----------------------------------------------------------------------------
// Block cache directory datapath
// Entry RAM with per-entry valid bits, scan tracking of hit and oldest free
// entry, entry update, release stamp counter and response register.
// ----------------------------------------------------------------------------
module bclru_datapath #(
   parameter int ENTRIES = bclru_pkg::DEFAULT_ENTRIES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bclru_pkg::ctrl_cmd_type    cmd,
   output bclru_pkg::dp_status_type   sts,
   input  bclru_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output bclru_pkg::rsp_payload_type rsp_payload
);
   import bclru_pkg::*;

   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ENTRY_BITS = $bits(entry_type);

   req_payload_type      req_ff;
   op_type               op;

   logic [ENTRIES-1:0]   valid_ff;
   logic                 rd_valid_ff;
   logic [IDX_W-1:0]     scan_cnt_ff;
   logic [IDX_W-1:0]     scan_addr_ff;
   logic                 scan_pend_ff;

   logic                 match_found_ff;
   logic                 match_found_in;
   logic [IDX_W-1:0]     match_idx_ff;
   logic [IDX_W-1:0]     match_idx_in;
   logic                 victim_found_ff;
   logic                 victim_found_in;
   logic [IDX_W-1:0]     victim_idx_ff;
   logic [IDX_W-1:0]     victim_idx_in;
   logic [STAMP_W-1:0]   victim_stamp_ff;
   logic [STAMP_W-1:0]   victim_stamp_in;

   logic [STAMP_W-1:0]   stamp_clock_ff;
   logic [STAMP_W-1:0]   stamp_next;
   logic                 stamp_bump;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_payload_type      rsp_payload_ff;
   rsp_payload_type      commit_rsp;
   rsp_payload_type      reject_rsp;

   logic [IDX_W-1:0]     target_idx;
   logic [ENTRY_W-1:0]   target_out;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [ENTRY_BITS-1:0] rd_data;
   entry_type            cur_entry;
   entry_type            new_entry;
   logic                 wr_needed;
   logic                 wr_en;
   logic [COUNT_W-1:0]   count_inc;
   logic [COUNT_W-1:0]   count_dec;
   logic                 slot_free;

   assign op         = op_type'(req_ff.operation);
   assign target_idx = (op == OP_GET) ? (match_found_ff ? match_idx_ff : victim_idx_ff)
                                      : IDX_W'(req_ff.entry_index);
   assign target_out = ENTRY_W'(target_idx);
   assign rd_en      = cmd.scan_step | cmd.target_read;
   assign rd_addr    = cmd.scan_step ? scan_cnt_ff : target_idx;
   assign cur_entry  = rd_valid_ff ? entry_type'(rd_data) : '0;
   assign count_inc  = cur_entry.count + COUNT_W'(1);
   assign count_dec  = cur_entry.count - COUNT_W'(1);
   assign stamp_next = stamp_clock_ff + STAMP_W'(1);
   assign wr_en      = cmd.commit & wr_needed;
   assign slot_free  = ~rsp_valid_ff | rsp_ready;

   bclru_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (target_idx),
      .wr_data (new_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // scan tracking: first tag match, and oldest free entry with lowest index on ties
   always_comb begin
      match_found_in  = match_found_ff;
      match_idx_in    = match_idx_ff;
      victim_found_in = victim_found_ff;
      victim_idx_in   = victim_idx_ff;
      victim_stamp_in = victim_stamp_ff;
      if (cmd.scan_start) begin
         match_found_in  = 1'b0;
         victim_found_in = 1'b0;
      end else if (scan_pend_ff) begin
         if (!match_found_ff && cur_entry.present && cur_entry.device == req_ff.device
             && cur_entry.block == req_ff.block_number) begin
            match_found_in = 1'b1;
            match_idx_in   = scan_addr_ff;
         end
         if (cur_entry.count == '0
             && (!victim_found_ff || cur_entry.stamp < victim_stamp_ff)) begin
            victim_found_in = 1'b1;
            victim_idx_in   = scan_addr_ff;
            victim_stamp_in = cur_entry.stamp;
         end
      end
   end

   // entry update and response for a transaction that reaches its target
   always_comb begin
      wr_needed             = 1'b0;
      stamp_bump            = 1'b0;
      new_entry             = cur_entry;
      commit_rsp.status     = STATUS_FAULT;
      commit_rsp.hit        = 1'b0;
      commit_rsp.needs_fill = 1'b0;
      commit_rsp.entry_out  = target_out;
      commit_rsp.count_out  = '0;
      unique case (op)
         OP_GET: begin
            if (match_found_ff) begin
               commit_rsp.hit = 1'b1;
               if (cur_entry.count == COUNT_MAX) begin
                  commit_rsp.count_out = COUNT_MAX;
               end else begin
                  wr_needed             = 1'b1;
                  new_entry.count       = count_inc;
                  new_entry.data_valid  = 1'b1;
                  commit_rsp.status     = STATUS_OK;
                  commit_rsp.needs_fill = ~cur_entry.data_valid;
                  commit_rsp.count_out  = count_inc;
               end
            end else begin
               // retag the victim, keep its stamp
               wr_needed             = 1'b1;
               new_entry.present     = 1'b1;
               new_entry.data_valid  = 1'b1;
               new_entry.count       = COUNT_W'(1);
               new_entry.device      = req_ff.device;
               new_entry.block       = req_ff.block_number;
               commit_rsp.status     = STATUS_OK;
               commit_rsp.needs_fill = 1'b1;
               commit_rsp.count_out  = COUNT_W'(1);
            end
         end
         OP_RELEASE: begin
            if (cur_entry.count != '0) begin
               wr_needed            = 1'b1;
               new_entry.count      = count_dec;
               commit_rsp.status    = STATUS_OK;
               commit_rsp.count_out = count_dec;
               if (count_dec == '0) begin
                  stamp_bump      = 1'b1;
                  new_entry.stamp = stamp_next;
               end
            end
         end
         OP_PIN: begin
            if (cur_entry.count == COUNT_MAX) begin
               commit_rsp.count_out = COUNT_MAX;
            end else begin
               wr_needed            = 1'b1;
               new_entry.count      = count_inc;
               commit_rsp.status    = STATUS_OK;
               commit_rsp.count_out = count_inc;
            end
         end
         OP_BAD: begin
            commit_rsp.entry_out = '0;
         end
      endcase
   end

   always_comb begin
      reject_rsp.hit        = 1'b0;
      reject_rsp.needs_fill = 1'b0;
      reject_rsp.count_out  = '0;
      priority if (op == OP_BAD) begin
         reject_rsp.status    = STATUS_FAULT;
         reject_rsp.entry_out = '0;
      end else if (op == OP_GET) begin
         reject_rsp.status    = STATUS_NO_FREE;
         reject_rsp.entry_out = '0;
      end else begin
         reject_rsp.status    = STATUS_FAULT;
         reject_rsp.entry_out = req_ff.entry_index;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.commit || cmd.reject) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= '0;
         scan_pend_ff    <= 1'b0;
         match_found_ff  <= 1'b0;
         victim_found_ff <= 1'b0;
         stamp_clock_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         scan_pend_ff    <= cmd.scan_step;
         match_found_ff  <= match_found_in;
         victim_found_ff <= victim_found_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[target_idx] <= 1'b1;
         end
         if (cmd.commit && stamp_bump) begin
            stamp_clock_ff <= stamp_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_payload;
      end
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.scan_start) begin
         scan_cnt_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_cnt_ff <= scan_cnt_ff + IDX_W'(1);
      end
      if (cmd.scan_step) begin
         scan_addr_ff <= scan_cnt_ff;
      end
      match_idx_ff    <= match_idx_in;
      victim_idx_ff   <= victim_idx_in;
      victim_stamp_ff <= victim_stamp_in;
      if (cmd.commit) begin
         rsp_payload_ff <= commit_rsp;
      end else if (cmd.reject) begin
         rsp_payload_ff <= reject_rsp;
      end
   end

   assign sts.op        = op;
   assign sts.index_ok  = 32'(req_ff.entry_index) < 32'(ENTRIES);
   assign sts.scan_last = scan_cnt_ff == IDX_W'(ENTRIES - 1);
   assign sts.found     = match_found_ff | victim_found_ff;
   assign sts.slot_free = slot_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `BCLRU_ASSERT_IMPLIES(a_write_in_range, clock, reset, wr_en, 32'(target_idx) < 32'(ENTRIES))
   `BCLRU_ASSERT_NEXT(a_stamp_on_commit, clock, reset, !cmd.commit, $stable(stamp_clock_ff))
   `BCLRU_ASSERT_IMPLIES(a_scan_no_write, clock, reset, scan_pend_ff, !wr_en)
endmodule

[rtl/block_cache_lru_directory_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block cache LRU directory
// Reference-counted directory of a disk-block cache with replacement of the
// least recently released unreferenced entry.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one transaction: get (device, block_number), release or
//   pin (entry_index). rsp_chan returns exactly one result per transaction:
//   status, hit, needs_fill, entry_out and count_out.
//   A get walks the entry RAM one entry per cycle through its single read
//   port, then reads its target entry and registers the result; a get that
//   finds neither a hit nor a free entry skips the target read and is
//   rejected. Release and pin read one entry and write it back when its
//   count changes. Requests rejected at dispatch go straight to the result
//   register without a read.
//   One transaction is in work at a time; req_chan is ready while idle, even
//   with a result still waiting on rsp_chan.
//   If rsp_chan stalls, the result register holds and a finished transaction
//   waits before its entry update until the register is free.
//   Reset is synchronous: it clears the per-entry valid bits (so every entry
//   reads as empty, count zero, stamp zero), the release stamp counter and
//   the response valid flag. No clearing pass is needed.
// ----------------------------------------------------------------------------
module block_cache_lru_directory_unit #(
   parameter int ENTRIES = bclru_pkg::DEFAULT_ENTRIES
) (
   input logic            clock,
   input logic            reset,
   bclru_stream_if.sink   req_chan,
   bclru_stream_if.source rsp_chan
);
   import bclru_pkg::*;

   ctrl_cmd_type    cmd;
   dp_status_type   sts;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   logic            req_ready;
   logic            rsp_valid;

   assign req_payload = req_chan.payload;

   bclru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bclru_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_payload)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;
endmodule
